[hdl/flk_pkg.sv]
// ============================================================================
// flk_pkg
// Shared types, constants and helpers for the leg forward kinematics core.
// ============================================================================
package flk_pkg;

    // fixed-point constants (Q30 angles, Q24 lengths)
    localparam logic [31:0]        Q30_ONE     = 32'd1073741824;
    localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
    localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [19:0] OUT_MAX     = 20'sd524287;
    localparam logic signed [19:0] OUT_MIN     = -20'sd524288;
    localparam int                 REC_SHIFT   = 36;

    // register reset values
    localparam logic [15:0] RST_FOOT_HEIGHT    = 16'd6029;
    localparam logic [15:0] RST_SHIN_LENGTH    = 16'd21627;
    localparam logic [15:0] RST_THIGH_LENGTH   = 16'd19661;
    localparam logic [15:0] RST_HIP_HEIGHT     = 16'd8061;
    localparam logic [15:0] RST_LATERAL_OFFSET = 16'd1147;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LEG_SIDE       = 3'd0,
        CFG_FOOT_HEIGHT    = 3'd1,
        CFG_SHIN_LENGTH    = 3'd2,
        CFG_THIGH_LENGTH   = 3'd3,
        CFG_HIP_HEIGHT     = 3'd4,
        CFG_LATERAL_OFFSET = 3'd5
    } t_cfg_idx;

    // rotation axis codes
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    typedef logic signed [31:0] t_crd;

    typedef struct packed {
        t_crd x;
        t_crd y;
        t_crd z;
    } t_vec3;

    // per-lane side info carried down the sine/cosine pipe
    typedef struct packed {
        logic [30:0] m;
        logic [31:0] m2;
        logic        xneg;
        logic        neg;
    } t_sc_side;

    // series divisors, innermost first; last step closes the series
    function automatic logic [7:0] sin_div(input int k);
        logic [7:0] d;
        case (k)
            0:       d = 8'd110;
            1:       d = 8'd72;
            2:       d = 8'd42;
            3:       d = 8'd20;
            4:       d = 8'd6;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] cos_div(input int k);
        logic [7:0] d;
        case (k)
            0:       d = 8'd132;
            1:       d = 8'd90;
            2:       d = 8'd56;
            3:       d = 8'd30;
            4:       d = 8'd12;
            default: d = 8'd2;
        endcase
        return d;
    endfunction

endpackage

[hdl/flk_sincos.sv]
// ============================================================================
// flk_sincos
// Pipelined Q30 sine/cosine of one Q3.13 angle: quadrant fold, then six
// series steps of multiply, reciprocal divide and correction.
// ============================================================================
module flk_sincos import flk_pkg::*; (
    input  logic               i_clk,
    input  logic signed [15:0] i_angle,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    // fold into [-pi/2, pi/2]
    logic signed [34:0] w_x;
    logic signed [34:0] w_red;
    logic               w_neg;
    logic signed [34:0] w_abs;
    t_sc_side           r_s0;

    always_comb begin
        w_x   = 35'(i_angle) <<< 17;
        w_red = w_x;
        w_neg = 1'b0;
        if (w_x > Q30_HALF_PI) begin
            w_red = w_x - Q30_PI;
            w_neg = 1'b1;
        end else if (w_x < -Q30_HALF_PI) begin
            w_red = w_x + Q30_PI;
            w_neg = 1'b1;
        end
        w_abs = (w_red < 0) ? -w_red : w_red;
    end

    always_ff @(posedge i_clk) begin
        r_s0.m    <= w_abs[30:0];
        r_s0.m2   <= '0;
        r_s0.xneg <= w_red[34];
        r_s0.neg  <= w_neg;
    end

    // m squared, rounded to Q30
    logic [61:0] w_sq;
    t_sc_side    w_sd [0:6];
    logic [31:0] w_ts [0:6];
    logic [31:0] w_tc [0:6];
    t_sc_side    r_s1;

    assign w_sq = r_s0.m * r_s0.m;

    always_ff @(posedge i_clk) begin
        r_s1.m    <= r_s0.m;
        r_s1.m2   <= 32'((w_sq + 62'(1 << 29)) >> 30);
        r_s1.xneg <= r_s0.xneg;
        r_s1.neg  <= r_s0.neg;
    end

    assign w_sd[0] = r_s1;
    assign w_ts[0] = Q30_ONE;
    assign w_tc[0] = Q30_ONE;

    // series steps, three stages each
    for (genvar k = 0; k < 6; k++) begin : g_it
        localparam logic [7:0]  SD = sin_div(k);
        localparam logic [7:0]  CD = cos_div(k);
        localparam logic [36:0] SR = 37'((64'd1 << REC_SHIFT) / 64'(SD));
        localparam logic [36:0] CR = 37'((64'd1 << REC_SHIFT) / 64'(CD));

        logic [31:0] w_ms;
        logic [63:0] r_ps, r_pc;
        logic [63:0] w_rs, w_rc;
        logic [32:0] r_xs, r_xc;
        logic [69:0] r_ys, r_yc;
        logic [33:0] w_qes, w_qec;
        logic [41:0] w_rems, w_remc;
        logic [33:0] w_qs, w_qc;
        logic [31:0] r_ts, r_tc;
        t_sc_side    r_sa, r_sb, r_sc;

        // final sine step multiplies by m instead of m2
        assign w_ms = (k == 5) ? {1'b0, w_sd[k].m} : w_sd[k].m2;

        // stage a: products
        always_ff @(posedge i_clk) begin
            r_ps <= w_ms * w_ts[k];
            r_pc <= w_sd[k].m2 * w_tc[k];
            r_sa <= w_sd[k];
        end

        // stage b: round to Q30 and multiply by reciprocal
        assign w_rs = r_ps + 64'(1 << 29);
        assign w_rc = r_pc + 64'(1 << 29);

        always_ff @(posedge i_clk) begin
            r_xs <= w_rs[62:30];
            r_xc <= w_rc[62:30];
            r_ys <= 70'(w_rs[62:30]) * 70'(SR);
            r_yc <= 70'(w_rc[62:30]) * 70'(CR);
            r_sb <= r_sa;
        end

        // stage c: quotient correction, series update
        always_comb begin
            w_qes  = r_ys[69:36];
            w_qec  = r_yc[69:36];
            w_rems = 42'(r_xs) - 42'(w_qes) * 42'(SD);
            w_remc = 42'(r_xc) - 42'(w_qec) * 42'(CD);
            w_qs   = w_qes + 34'(w_rems >= 42'(SD));
            w_qc   = w_qec + 34'(w_remc >= 42'(CD));
        end

        always_ff @(posedge i_clk) begin
            if (k == 5) begin
                r_ts <= w_qs[31:0];
            end else begin
                r_ts <= Q30_ONE - w_qs[31:0];
            end
            r_tc <= Q30_ONE - w_qc[31:0];
            r_sc <= r_sb;
        end

        assign w_sd[k+1] = r_sc;
        assign w_ts[k+1] = r_ts;
        assign w_tc[k+1] = r_tc;
    end

    // sign fix-up
    logic signed [31:0] w_s1;

    assign w_s1 = w_sd[6].xneg ? -$signed(w_ts[6]) : $signed(w_ts[6]);

    always_ff @(posedge i_clk) begin
        o_sin <= w_sd[6].neg ? -w_s1 : w_s1;
        o_cos <= w_sd[6].neg ? -$signed(w_tc[6]) : $signed(w_tc[6]);
    end

endmodule

[hdl/flk_rot.sv]
// ============================================================================
// flk_rot
// One joint: rotate the point about a unit axis through a center.
// Two stages: products, then rounded sums back to Q24.
// ============================================================================
module flk_rot import flk_pkg::*; #(
    parameter int AXIS = AXIS_X
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  t_vec3              i_p,
    input  t_vec3              i_ctr,
    input  logic signed [31:0] i_sin,
    input  logic signed [31:0] i_cos,
    output logic               o_vld,
    output t_vec3              o_p
);

    // Q30 by Q24 sum, rounded half away from zero
    function automatic t_crd rnd30(input logic signed [64:0] v);
        logic signed [64:0] r;
        if (v >= 0) begin
            r = (v + 65'sd536870912) >>> 30;
        end else begin
            r = -((-v + 65'sd536870912) >>> 30);
        end
        return r[31:0];
    endfunction

    t_crd w_pa, w_pb, w_ca, w_cb, w_da, w_db;

    // pick the two coordinates turned by this axis
    always_comb begin
        case (AXIS)
            AXIS_X: begin
                w_pa = i_p.y;   w_pb = i_p.z;
                w_ca = i_ctr.y; w_cb = i_ctr.z;
            end
            AXIS_Y: begin
                w_pa = i_p.z;   w_pb = i_p.x;
                w_ca = i_ctr.z; w_cb = i_ctr.x;
            end
            default: begin
                w_pa = i_p.x;   w_pb = i_p.y;
                w_ca = i_ctr.x; w_cb = i_ctr.y;
            end
        endcase
        w_da = w_pa - w_ca;
        w_db = w_pb - w_cb;
    end

    // stage 1: products
    logic               r_vld1;
    t_vec3              r_p1, r_c1;
    logic signed [63:0] r_ca, r_sb, r_sa, r_cb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
        end
        r_p1 <= i_p;
        r_c1 <= i_ctr;
        r_ca <= i_cos * w_da;
        r_sb <= i_sin * w_db;
        r_sa <= i_sin * w_da;
        r_cb <= i_cos * w_db;
    end

    // stage 2: sums and center offset
    t_crd  w_na, w_nb;
    t_vec3 w_np;

    always_comb begin
        w_np = r_p1;
        case (AXIS)
            AXIS_X: begin
                w_na   = r_c1.y + rnd30(65'(r_ca) - 65'(r_sb));
                w_nb   = r_c1.z + rnd30(65'(r_sa) + 65'(r_cb));
                w_np.y = w_na;
                w_np.z = w_nb;
            end
            AXIS_Y: begin
                w_na   = r_c1.z + rnd30(65'(r_ca) - 65'(r_sb));
                w_nb   = r_c1.x + rnd30(65'(r_sa) + 65'(r_cb));
                w_np.z = w_na;
                w_np.x = w_nb;
            end
            default: begin
                w_na   = r_c1.x + rnd30(65'(r_ca) - 65'(r_sb));
                w_nb   = r_c1.y + rnd30(65'(r_sa) + 65'(r_cb));
                w_np.x = w_na;
                w_np.y = w_nb;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r_vld1;
        end
        o_p <= w_np;
    end

endmodule

[hdl/leg_forward_kinematics_core.sv]
// ============================================================================
// leg_forward_kinematics_core
// Hip position from six joint angles by the product of exponentials.
// ============================================================================
// Path from start to o_valid: the sine/cosine pipes, then the joint rotations,
//   then output rounding and saturation.
// Throughput: one pose per cycle; busy stays low, every beat flows through.
// Reset: synchronous active-low; clears valid bits and loads register defaults.
// Results are shown for one cycle; the receiver cannot stall.
module leg_forward_kinematics_core import flk_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_angle_0,
    input  logic signed [15:0] i_angle_1,
    input  logic signed [15:0] i_angle_2,
    input  logic signed [15:0] i_angle_3,
    input  logic signed [15:0] i_angle_4,
    input  logic signed [15:0] i_angle_5,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [19:0] o_pos_x,
    output logic signed [19:0] o_pos_y,
    output logic signed [19:0] o_pos_z
);

    localparam int SC_LAT = 21;

    assign busy = 1'b0;

    // configuration registers
    logic        r_leg_side;
    logic [15:0] r_foot_height, r_shin_length, r_thigh_length;
    logic [15:0] r_hip_height, r_lateral_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leg_side       <= 1'b0;
            r_foot_height    <= RST_FOOT_HEIGHT;
            r_shin_length    <= RST_SHIN_LENGTH;
            r_thigh_length   <= RST_THIGH_LENGTH;
            r_hip_height     <= RST_HIP_HEIGHT;
            r_lateral_offset <= RST_LATERAL_OFFSET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LEG_SIDE:       r_leg_side       <= i_cfg_data[0];
                CFG_FOOT_HEIGHT:    r_foot_height    <= i_cfg_data;
                CFG_SHIN_LENGTH:    r_shin_length    <= i_cfg_data;
                CFG_THIGH_LENGTH:   r_thigh_length   <= i_cfg_data;
                CFG_HIP_HEIGHT:     r_hip_height     <= i_cfg_data;
                CFG_LATERAL_OFFSET: r_lateral_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // joint centers and home point in Q24 (user keeps static while poses flow; not enforced)
    t_crd  w_l9, w_l11, w_l12, w_l16, w_big, w_sy;
    t_vec3 w_ctr [0:5];
    t_vec3 w_home;

    always_comb begin
        w_l9  = t_crd'({r_foot_height, 8'b0});
        w_l11 = t_crd'({r_thigh_length, 8'b0});
        w_l12 = t_crd'({r_hip_height, 8'b0});
        w_l16 = t_crd'({r_lateral_offset, 8'b0});
        w_big = t_crd'({r_shin_length, 8'b0}) + w_l11 + w_l12;
        w_sy  = r_leg_side ? w_l16 : -w_l16;
        w_ctr[0] = '{x: '0, y: '0,   z: w_l12};
        w_ctr[1] = '{x: '0, y: '0,   z: w_l12};
        w_ctr[2] = '{x: '0, y: '0,   z: w_l11 + w_l12};
        w_ctr[3] = '{x: '0, y: '0,   z: w_big};
        w_ctr[4] = '{x: '0, y: w_sy, z: w_big};
        w_ctr[5] = '{x: '0, y: w_sy, z: '0};
        w_home   = '{x: '0, y: w_sy, z: w_l9 + w_big};
    end

    // sine/cosine lanes, one per joint
    logic signed [15:0] w_ang [0:5];
    logic signed [31:0] w_sin [0:5];
    logic signed [31:0] w_cos [0:5];

    assign w_ang[0] = i_angle_0;
    assign w_ang[1] = i_angle_1;
    assign w_ang[2] = i_angle_2;
    assign w_ang[3] = i_angle_3;
    assign w_ang[4] = i_angle_4;
    assign w_ang[5] = i_angle_5;

    for (genvar j = 0; j < 6; j++) begin : g_sc
        flk_sincos u_sc (
            .i_clk   (i_clk),
            .i_angle (w_ang[j]),
            .o_sin   (w_sin[j]),
            .o_cos   (w_cos[j])
        );
    end

    // valid bits alongside the sine/cosine pipes
    logic r_vsc [0:SC_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SC_LAT; i++) begin
                r_vsc[i] <= 1'b0;
            end
        end else begin
            r_vsc[0] <= start & ~busy;
            for (int i = 1; i < SC_LAT; i++) begin
                r_vsc[i] <= r_vsc[i-1];
            end
        end
    end

    // rotation chain, joint 0 first; later joints' sine/cosine wait in delay registers
    logic  w_vld [0:6];
    t_vec3 w_p   [0:6];

    assign w_vld[0] = r_vsc[SC_LAT-1];
    assign w_p[0]   = w_home;

    for (genvar j = 0; j < 6; j++) begin : g_rot
        localparam int AX = (j == 0 || j == 4) ? AXIS_X : ((j == 5) ? AXIS_Z : AXIS_Y);
        logic signed [31:0] w_s, w_c;

        if (j == 0) begin : g_nd
            assign w_s = w_sin[j];
            assign w_c = w_cos[j];
        end else begin : g_dl
            logic signed [31:0] r_ds [0:2*j-1];
            logic signed [31:0] r_dc [0:2*j-1];

            always_ff @(posedge i_clk) begin
                r_ds[0] <= w_sin[j];
                r_dc[0] <= w_cos[j];
                for (int i = 1; i < 2 * j; i++) begin
                    r_ds[i] <= r_ds[i-1];
                    r_dc[i] <= r_dc[i-1];
                end
            end

            assign w_s = r_ds[2*j-1];
            assign w_c = r_dc[2*j-1];
        end

        flk_rot #(.AXIS(AX)) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[j]),
            .i_p     (w_p[j]),
            .i_ctr   (w_ctr[j]),
            .i_sin   (w_s),
            .i_cos   (w_c),
            .o_vld   (w_vld[j+1]),
            .o_p     (w_p[j+1])
        );
    end

    // Q24 to Q16, half away from zero, then saturate
    function automatic logic signed [19:0] to_out(input t_crd v);
        logic signed [32:0] r;
        logic signed [19:0] o;
        if (v >= 0) begin
            r = (33'(v) + 33'sd128) >>> 8;
        end else begin
            r = -((-33'(v) + 33'sd128) >>> 8);
        end
        if (r > 33'(OUT_MAX)) begin
            o = OUT_MAX;
        end else if (r < 33'(OUT_MIN)) begin
            o = OUT_MIN;
        end else begin
            o = r[19:0];
        end
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_vld[6];
        end
        o_pos_x <= to_out(w_p[6].x);
        o_pos_y <= to_out(w_p[6].y);
        o_pos_z <= to_out(w_p[6].z);
    end

endmodule

[tb/tb.sv]
// ============================================================================
// tb
// Checks leg_forward_kinematics_core: random and edge-case joint poses against
// a local bit-exact predictor of the chained joint rotations, over several
// link-length and leg-side settings.
// ============================================================================
`timescale 1ns / 1ps

module tb;
    import flk_pkg::*;

    localparam int LATENCY = 34;

    typedef struct {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
    } t_hip_pos;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_angle_0, i_angle_1, i_angle_2;
    logic signed [15:0] i_angle_3, i_angle_4, i_angle_5;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               o_valid;
    logic signed [19:0] o_pos_x, o_pos_y, o_pos_z;

    // local copy of the link registers
    logic        side_r;
    logic [15:0] len_r [6];

    t_hip_pos pos_q[$];
    int       n_err;
    int       n_res;
    bit       idle_on;

    leg_forward_kinematics_core uut (.*);

    // clock
    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint round_shr(longint v, int n);
        longint half;
        half = longint'(1) << (n - 1);
        if (v >= 0) return (v + half) >>> n;
        return -((-v + half) >>> n);
    endfunction

    task automatic joint_sincos(input logic signed [15:0] ang, output longint s,
                                output longint c);
        longint x;
        longint unsigned m, m2, t;
        bit neg;
        longint unsigned sd [5];
        longint unsigned cd [5];
        sd = '{110, 72, 42, 20, 6};
        cd = '{132, 90, 56, 30, 12};
        neg = 0;
        x = longint'(ang) * 131072;
        if (x > longint'(Q30_HALF_PI)) begin
            x -= longint'(Q30_PI); neg = 1;
        end else if (x < -longint'(Q30_HALF_PI)) begin
            x += longint'(Q30_PI); neg = 1;
        end
        m = (x < 0) ? -x : x;
        m2 = mul_q30(m, m);
        t = Q30_ONE;
        for (int i = 0; i < 5; i++) t = Q30_ONE - mul_q30(m2, t) / sd[i];
        s = mul_q30(m, t);
        if (x < 0) s = -s;
        t = Q30_ONE;
        for (int i = 0; i < 5; i++) t = Q30_ONE - mul_q30(m2, t) / cd[i];
        c = longint'(Q30_ONE) - longint'(mul_q30(m2, t) / 2);
        if (neg) begin
            s = -s; c = -c;
        end
    endtask

    function automatic logic signed [19:0] sat_out(longint v);
        longint r;
        r = round_shr(v, 8);
        if (r > 524287) r = 524287;
        if (r < -524288) r = -524288;
        return r[19:0];
    endfunction

    task automatic predict_hip(input logic signed [15:0] ang [6], output t_hip_pos hp);
        longint l9, l10, l11, l12, l16, lsum, sy, s, c, da, db;
        longint ctr [6][3];
        longint p [3];
        int axes [6];
        int ia, ib;
        axes = '{AXIS_X, AXIS_Y, AXIS_Y, AXIS_Y, AXIS_X, AXIS_Z};
        l9  = longint'(len_r[CFG_FOOT_HEIGHT]) * 256;
        l10 = longint'(len_r[CFG_SHIN_LENGTH]) * 256;
        l11 = longint'(len_r[CFG_THIGH_LENGTH]) * 256;
        l12 = longint'(len_r[CFG_HIP_HEIGHT]) * 256;
        l16 = longint'(len_r[CFG_LATERAL_OFFSET]) * 256;
        lsum = l10 + l11 + l12;
        sy = side_r ? l16 : -l16;
        foreach (ctr[j, k]) ctr[j][k] = 0;
        ctr[0][2] = l12;
        ctr[1][2] = l12;
        ctr[2][2] = l11 + l12;
        ctr[3][2] = lsum;
        ctr[4][1] = sy;
        ctr[4][2] = lsum;
        ctr[5][1] = sy;
        p[0] = 0; p[1] = sy; p[2] = l9 + lsum;
        for (int j = 0; j < 6; j++) begin
            joint_sincos(ang[j], s, c);
            ia = (axes[j] + 1) % 3;
            ib = (axes[j] + 2) % 3;
            da = p[ia] - ctr[j][ia];
            db = p[ib] - ctr[j][ib];
            p[ia] = ctr[j][ia] + round_shr(c * da - s * db, 30);
            p[ib] = ctr[j][ib] + round_shr(s * da + c * db, 30);
        end
        hp.x = sat_out(p[0]);
        hp.y = sat_out(p[1]);
        hp.z = sat_out(p[2]);
    endtask

    // ---------------- drivers ----------------
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LEG_SIDE) side_r = val[0];
        else len_r[idx] = val;
    endtask

    // beat with one pose; optional idle burst before it
    task automatic send_pose(input logic signed [15:0] ang [6]);
        t_hip_pos hp;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_angle_0 <= ang[0]; i_angle_1 <= ang[1]; i_angle_2 <= ang[2];
        i_angle_3 <= ang[3]; i_angle_4 <= ang[4]; i_angle_5 <= ang[5];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_hip(ang, hp);
        pos_q.push_back(hp);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pos_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000 + 16'($urandom_range(0, 50));
            1:       return 16'sh7fff - 16'($urandom_range(0, 50));
            // near +-pi/2, where the reduction kicks in
            2:       return 16'sd12868 + $signed(16'($urandom_range(0, 8))) - 16'sd4;
            3:       return -16'sd12868 + $signed(16'($urandom_range(0, 8))) - 16'sd4;
            default: return 16'($urandom());
        endcase
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_hip_pos hp;
        if (i_rst_n && o_valid) begin
            n_res++;
            if (pos_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result beat x=%0d y=%0d z=%0d",
                                          o_pos_x, o_pos_y, o_pos_z);
            end else begin
                hp = pos_q.pop_front();
                if (o_pos_x !== hp.x || o_pos_y !== hp.y || o_pos_z !== hp.z) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch exp (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                                 hp.x, hp.y, hp.z, o_pos_x, o_pos_y, o_pos_z);
                end
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_edge_angles();
        logic signed [15:0] a [6];
        logic signed [15:0] v [8];
        v = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd12868, -16'sd12868,
              16'sd12869, -16'sd12869, 16'sd25736};
        foreach (v[i]) begin
            a = '{v[i], v[i], v[i], v[i], v[i], v[i]};
            send_pose(a);
        end
        // each joint alone at one extreme
        for (int j = 0; j < 6; j++) begin
            a = '{0, 0, 0, 0, 0, 0};
            a[j] = (j % 2) ? 16'sh8000 : 16'sh7fff;
            send_pose(a);
        end
        a = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
        send_pose(a);
        a = '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa};
        send_pose(a);
        drain();
    endtask

    task automatic test_random_poses(input int n);
        logic signed [15:0] a [6];
        repeat (n) begin
            foreach (a[j]) a[j] = ($urandom_range(0, 2) == 0) ? rand_angle()
                                                             : 16'($urandom());
            send_pose(a);
        end
        drain();
    endtask

    // one link setting, then random poses under it
    task automatic test_link_setting(input logic side, input logic [15:0] l9,
                                     input logic [15:0] l10, input logic [15:0] l11,
                                     input logic [15:0] l12, input logic [15:0] l16,
                                     input int n);
        write_reg(CFG_LEG_SIDE, {15'd0, side});
        write_reg(CFG_FOOT_HEIGHT, l9);
        write_reg(CFG_SHIN_LENGTH, l10);
        write_reg(CFG_THIGH_LENGTH, l11);
        write_reg(CFG_HIP_HEIGHT, l12);
        write_reg(CFG_LATERAL_OFFSET, l16);
        test_random_poses(n);
    endtask

    // ---------------- main ----------------
    initial begin
        i_rst_n = 1'b0; start = 1'b0; i_cfg_we = 1'b0;
        i_cfg_idx = CFG_LEG_SIDE; i_cfg_data = '0;
        i_angle_0 = '0; i_angle_1 = '0; i_angle_2 = '0;
        i_angle_3 = '0; i_angle_4 = '0; i_angle_5 = '0;
        n_err = 0; n_res = 0; idle_on = 1;
        side_r = 1'b0;
        len_r[0] = '0;
        len_r[CFG_FOOT_HEIGHT]    = RST_FOOT_HEIGHT;
        len_r[CFG_SHIN_LENGTH]    = RST_SHIN_LENGTH;
        len_r[CFG_THIGH_LENGTH]   = RST_THIGH_LENGTH;
        len_r[CFG_HIP_HEIGHT]     = RST_HIP_HEIGHT;
        len_r[CFG_LATERAL_OFFSET] = RST_LATERAL_OFFSET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_angles();
        test_random_poses(100);
        test_link_setting(1'b1, 16'd6029, 16'd21627, 16'd19661, 16'd8061, 16'd1147, 90);
        test_link_setting(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 80);
        test_link_setting(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 40);
        test_link_setting(1'b1, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 60);
        test_link_setting(1'b0, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom()), 16'($urandom()), 100);
        idle_on = 0;  // back-to-back beats at the end
        test_link_setting(1'b1, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom()), 16'($urandom()), 110);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("covered edge and random poses on both legs, %0d results, six link settings",
                 n_res);
        if (n_err == 0 && pos_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("%0d errors, %0d results still pending", n_err, pos_q.size());
            $display("tb failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("timeout");
        $display("tb failed");
        $finish;
    end

endmodule

[sim.f]
hdl/flk_pkg.sv
hdl/flk_sincos.sv
hdl/flk_rot.sv
hdl/leg_forward_kinematics_core.sv
tb/tb.sv
